@@ design/assert_macros.svh @@
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property must hold at every clock edge outside reset.
`define ASSERT_PROP(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// Condition must never be true outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition seen");

`else

`define ASSERT_PROP(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, cond)

`endif

`endif

@@ design/nta_pkg.sv @@
package nta_pkg;

  // One table entry as held in the table memory.
  typedef struct packed {
    logic [15:0] id;
    logic [1:0]  dir;
    logic [31:0] ts;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // Result of the shared compare unit.
  typedef struct packed {
    logic id_hit;
    logic stale;
  } cmp_t;

  typedef enum logic [2:0] {
    ST_UPDATED  = 3'd0,
    ST_INSERTED = 3'd1,
    ST_FULL     = 3'd2,
    ST_SHORT    = 3'd3,
    ST_BAD_DIR  = 3'd4,
    ST_OWN_ID   = 3'd5,
    ST_TICK     = 3'd6
  } status_t;

  localparam logic CMD_BEACON = 1'b0;
  localparam logic CMD_TICK   = 1'b1;

  localparam logic CFG_OWN_ID  = 1'b0;
  localparam logic CFG_MAX_AGE = 1'b1;

  localparam logic [7:0]  MIN_PAYLOAD = 8'd2;
  localparam logic [15:0] MAX_AGE_RST = 16'd1500;
  localparam int          DIR_SLOTS   = 4;
  localparam int          OUT_CNT_W   = 5;

endpackage

@@ design/neighbor_table_aging.sv @@
// Neighbor table with aging.
// Input channel (in_valid / in_stall): one item per command. A beacon
// (in_cmd = 0) refreshes or appends the sender's entry; a tick (in_cmd = 1)
// purges entries older than max_age_ms and recounts entries per direction.
// Result channel (out_valid / out_stall): exactly one result per item, held
// in an output register until taken. A new item is taken as soon as the
// sequencer is back in idle, even while the last result still waits.
// Configuration: cfg_we with cfg_index 0 writes own_id, 1 writes max_age_ms;
// write only while the block is idle.
// Steps, with N entries held: a dropped beacon goes straight to the result;
// a beacon reads and compares each entry scanned in turn, and takes an insert
// step when no entry matches (insert or table full).
// A tick checks each entry, copies the last entry over each swapped one,
// then reads each surviving entry to recount it. Every entry read goes through
// the single read port of the table memory; the checks use the one compare unit.
// A stalled result blocks the sequencer only at its final step.
// Reset (rst_n low, synchronous) empties the table, clears the counts and
// loads own_id 0 and max_age_ms 1500; no clearing pass is needed.
module neighbor_table_aging #(
  parameter int MAX_ENTRIES = 20,
  parameter int DIRECTIONS  = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_cmd,
  input  logic [15:0] in_sender_id,
  input  logic [2:0]  in_direction,
  input  logic [7:0]  in_payload_len,
  input  logic [31:0] in_now_ms,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_status,
  output logic [4:0]  out_neighbor_count,
  output logic [4:0]  out_removed_count,
  output logic [4:0]  out_dir_count_0,
  output logic [4:0]  out_dir_count_1,
  output logic [4:0]  out_dir_count_2,
  output logic [4:0]  out_dir_count_3
);
  import nta_pkg::*;

`include "assert_macros.svh"

  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam logic [CW-1:0] CNT_MAX = CW'(MAX_ENTRIES);
  localparam logic [CW-1:0] CNT_ONE = CW'(1);
  localparam logic [3:0]    DIR_LIM = 4'(DIRECTIONS);

  typedef enum logic [3:0] {
    S_IDLE, S_B_RD, S_B_CMP, S_B_INS, S_T_RD, S_T_CHK, S_T_CPY,
    S_C_START, S_C_RD, S_C_ACC, S_DONE
  } state_t;

  state_t            state_r, state_nxt;
  logic [IW-1:0]     idx_r, idx_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic [CW-1:0]     removed_r, removed_nxt;
  status_t           status_r, status_nxt;
  logic [CW-1:0]     dir_cnt_r [DIR_SLOTS];
  logic [CW-1:0]     dir_cnt_nxt [DIR_SLOTS];
  logic [15:0]       own_id_r, own_id_nxt;
  logic [15:0]       max_age_r, max_age_nxt;
  logic [15:0]       sender_r, sender_nxt;
  logic [1:0]        dir_r, dir_nxt;
  logic [31:0]       now_r, now_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [2:0]        out_status_r, out_status_nxt;
  logic [4:0]        out_count_r, out_count_nxt;
  logic [4:0]        out_removed_r, out_removed_nxt;
  logic [4:0]        out_dir_r [DIR_SLOTS];
  logic [4:0]        out_dir_nxt [DIR_SLOTS];

  logic              ram_we;
  logic [IW-1:0]     ram_waddr;
  entry_t            ram_wdata;
  logic [IW-1:0]     ram_raddr;
  entry_t            ram_rdata;
  cmp_t              cmp;
  logic              t_adv;

  nta_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_ENTRIES)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  nta_cmp_unit u_cmp (
    .entry_i   (ram_rdata),
    .sender_i  (sender_r),
    .now_i     (now_r),
    .max_age_i (max_age_r),
    .res_o     (cmp)
  );

  assign in_stall = state_r != S_IDLE;

  always_comb begin
    state_nxt       = state_r;
    idx_nxt         = idx_r;
    count_nxt       = count_r;
    removed_nxt     = removed_r;
    status_nxt      = status_r;
    dir_cnt_nxt     = dir_cnt_r;
    own_id_nxt      = own_id_r;
    max_age_nxt     = max_age_r;
    sender_nxt      = sender_r;
    dir_nxt         = dir_r;
    now_nxt         = now_r;
    out_valid_nxt   = out_valid_r;
    out_status_nxt  = out_status_r;
    out_count_nxt   = out_count_r;
    out_removed_nxt = out_removed_r;
    out_dir_nxt     = out_dir_r;
    ram_we          = 1'b0;
    ram_waddr       = idx_r;
    ram_wdata       = '{id: sender_r, dir: dir_r, ts: now_r};
    ram_raddr       = idx_r;
    t_adv           = 1'b0;

    if (cfg_we) begin
      case (cfg_index)
        CFG_OWN_ID:  own_id_nxt  = cfg_wdata;
        CFG_MAX_AGE: max_age_nxt = cfg_wdata;
        default:     own_id_nxt  = own_id_r;
      endcase
    end

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          sender_nxt  = in_sender_id;
          dir_nxt     = in_direction[1:0];
          now_nxt     = in_now_ms;
          removed_nxt = '0;
          idx_nxt     = '0;
          if (in_cmd == CMD_TICK) begin
            status_nxt = ST_TICK;
            if (count_r == '0) begin
              state_nxt = S_C_START;
            end else begin
              idx_nxt   = IW'(count_r - CNT_ONE);
              state_nxt = S_T_RD;
            end
          end else if (in_payload_len < MIN_PAYLOAD) begin
            status_nxt = ST_SHORT;
            state_nxt  = S_DONE;
          end else if ({1'b0, in_direction} >= DIR_LIM) begin
            status_nxt = ST_BAD_DIR;
            state_nxt  = S_DONE;
          end else if (in_sender_id == own_id_r) begin
            status_nxt = ST_OWN_ID;
            state_nxt  = S_DONE;
          end else if (count_r == '0) begin
            state_nxt = S_B_INS;
          end else begin
            state_nxt = S_B_RD;
          end
        end
      end

      S_B_RD: state_nxt = S_B_CMP;

      S_B_CMP: begin
        if (cmp.id_hit) begin
          ram_we     = 1'b1;
          status_nxt = ST_UPDATED;
          state_nxt  = S_DONE;
        end else if ((CW'(idx_r) + CNT_ONE) == count_r) begin
          state_nxt = S_B_INS;
        end else begin
          idx_nxt   = idx_r + IW'(1);
          state_nxt = S_B_RD;
        end
      end

      S_B_INS: begin
        if (count_r == CNT_MAX) begin
          status_nxt = ST_FULL;
        end else begin
          ram_we     = 1'b1;
          ram_waddr  = IW'(count_r);
          count_nxt  = count_r + CNT_ONE;
          status_nxt = ST_INSERTED;
        end
        state_nxt = S_DONE;
      end

      S_T_RD: state_nxt = S_T_CHK;

      S_T_CHK: begin
        if (cmp.stale) begin
          if (CW'(idx_r) == (count_r - CNT_ONE)) begin
            // Stale entry is the last one: just drop it.
            count_nxt   = count_r - CNT_ONE;
            removed_nxt = removed_r + CNT_ONE;
            t_adv       = 1'b1;
          end else begin
            ram_raddr = IW'(count_r - CNT_ONE);
            state_nxt = S_T_CPY;
          end
        end else begin
          t_adv = 1'b1;
        end
      end

      S_T_CPY: begin
        // Overwrite the stale entry with the last one.
        ram_we      = 1'b1;
        ram_wdata   = ram_rdata;
        count_nxt   = count_r - CNT_ONE;
        removed_nxt = removed_r + CNT_ONE;
        t_adv       = 1'b1;
      end

      S_C_START: begin
        for (int d = 0; d < DIR_SLOTS; d++) begin
          dir_cnt_nxt[d] = '0;
        end
        idx_nxt   = '0;
        state_nxt = (count_r == '0) ? S_DONE : S_C_RD;
      end

      S_C_RD: state_nxt = S_C_ACC;

      S_C_ACC: begin
        dir_cnt_nxt[ram_rdata.dir] = dir_cnt_r[ram_rdata.dir] + CNT_ONE;
        if ((CW'(idx_r) + CNT_ONE) == count_r) begin
          state_nxt = S_DONE;
        end else begin
          idx_nxt   = idx_r + IW'(1);
          state_nxt = S_C_RD;
        end
      end

      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt   = 1'b1;
          out_status_nxt  = status_r;
          out_count_nxt   = OUT_CNT_W'(count_r);
          out_removed_nxt = OUT_CNT_W'(removed_r);
          for (int d = 0; d < DIR_SLOTS; d++) begin
            out_dir_nxt[d] = OUT_CNT_W'(dir_cnt_r[d]);
          end
          state_nxt = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase

    // Move the purge walk one entry down, or start the recount.
    if (t_adv) begin
      if (idx_r == '0) begin
        state_nxt = S_C_START;
      end else begin
        idx_nxt   = idx_r - IW'(1);
        state_nxt = S_T_RD;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      own_id_r    <= '0;
      max_age_r   <= MAX_AGE_RST;
      for (int d = 0; d < DIR_SLOTS; d++) begin
        dir_cnt_r[d] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      own_id_r    <= own_id_nxt;
      max_age_r   <= max_age_nxt;
      dir_cnt_r   <= dir_cnt_nxt;
    end
    idx_r         <= idx_nxt;
    removed_r     <= removed_nxt;
    status_r      <= status_nxt;
    sender_r      <= sender_nxt;
    dir_r         <= dir_nxt;
    now_r         <= now_nxt;
    out_status_r  <= out_status_nxt;
    out_count_r   <= out_count_nxt;
    out_removed_r <= out_removed_nxt;
    out_dir_r     <= out_dir_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_neighbor_count = out_count_r;
  assign out_removed_count  = out_removed_r;
  assign out_dir_count_0    = out_dir_r[0];
  assign out_dir_count_1    = out_dir_r[1];
  assign out_dir_count_2    = out_dir_r[2];
  assign out_dir_count_3    = out_dir_r[3];

  `ASSERT_NEVER(a_count_bound, clk, rst_n, count_r > CNT_MAX)
  `ASSERT_PROP(a_we_states, clk, rst_n,
    ram_we |-> (state_r == S_B_CMP || state_r == S_B_INS || state_r == S_T_CPY))
  `ASSERT_PROP(a_result_from_done, clk, rst_n,
    $rose(out_valid_r) |-> $past(state_r == S_DONE))
  `ASSERT_PROP(a_purge_no_grow, clk, rst_n,
    (state_r == S_T_CHK || state_r == S_T_CPY) |=> count_r <= $past(count_r))

endmodule

@@ design/nta_ram.sv @@
module nta_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

@@ design/nta_cmp_unit.sv @@
module nta_cmp_unit (
  input  nta_pkg::entry_t entry_i,
  input  logic [15:0]     sender_i,
  input  logic [31:0]     now_i,
  input  logic [15:0]     max_age_i,
  output nta_pkg::cmp_t   res_o
);
  import nta_pkg::*;

  logic [31:0] age;

  // Wrapping age of the entry.
  assign age          = now_i - entry_i.ts;
  assign res_o.stale  = age > {16'd0, max_age_i};
  assign res_o.id_hit = entry_i.id == sender_i;

endmodule

@@ dv/tb_neighbor_table_aging.sv @@
module tb_neighbor_table_aging;
  timeunit 1ns;
  timeprecision 1ps;

  import nta_pkg::*;

  localparam int TBL_DEPTH   = 20;
  localparam int DIR_NUM     = 4;
  localparam int POOL_SIZE   = 24;
  localparam int CYCLE_LIMIT = 1_500_000;
  localparam int HOLD_AT     = 150;
  localparam int HOLD_LEN    = 500;

  typedef struct packed {
    logic        cmd;
    logic [15:0] sender;
    logic [2:0]  dir;
    logic [7:0]  len;
    logic [31:0] now;
  } radio_item_t;

  typedef struct packed {
    status_t         status;
    logic [4:0]      count;
    logic [4:0]      removed;
    logic [3:0][4:0] dir_cnt;
  } table_report_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic        cfg_index = 1'b0;
  logic [15:0] cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_cmd = 1'b0;
  logic [15:0] in_sender_id = '0;
  logic [2:0]  in_direction = '0;
  logic [7:0]  in_payload_len = '0;
  logic [31:0] in_now_ms = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  out_status;
  logic [4:0]  out_neighbor_count;
  logic [4:0]  out_removed_count;
  logic [4:0]  out_dir_count_0;
  logic [4:0]  out_dir_count_1;
  logic [4:0]  out_dir_count_2;
  logic [4:0]  out_dir_count_3;

  // Shadow copy of the neighbor table and its registers.
  logic [15:0] own_id_q = '0;
  logic [15:0] max_age_q = MAX_AGE_RST;
  logic [15:0] tbl_id [TBL_DEPTH];
  logic [1:0]  tbl_dir [TBL_DEPTH];
  logic [31:0] tbl_ts [TBL_DEPTH];
  int          tbl_n = 0;
  int          dir_tally [DIR_NUM];

  radio_item_t   pending_items [$];
  table_report_t expected_reports [$];
  radio_item_t   on_wire;
  table_report_t want;
  logic [15:0]   pool [POOL_SIZE];
  logic [3:0][4:0] got_dirs;

  int queued_total = 0;
  int checked_total = 0;
  int errors = 0;
  int cycle_cnt = 0;
  int tx_wait = 0;
  int tx_quiet = 0;
  int rx_hold = 0;
  int rx_quiet = 0;
  int d;
  bit held_off = 1'b0;

  neighbor_table_aging #(
    .MAX_ENTRIES(TBL_DEPTH),
    .DIRECTIONS (DIR_NUM)
  ) DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_cmd            (in_cmd),
    .in_sender_id      (in_sender_id),
    .in_direction      (in_direction),
    .in_payload_len    (in_payload_len),
    .in_now_ms         (in_now_ms),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_status        (out_status),
    .out_neighbor_count(out_neighbor_count),
    .out_removed_count (out_removed_count),
    .out_dir_count_0   (out_dir_count_0),
    .out_dir_count_1   (out_dir_count_1),
    .out_dir_count_2   (out_dir_count_2),
    .out_dir_count_3   (out_dir_count_3)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Apply one item to the shadow table and return the report it produces.
  function automatic table_report_t update_neighbors(radio_item_t it);
    table_report_t r;
    int k;
    int slot;
    int last;
    int purged;
    logic [31:0] age;
    purged = 0;
    if (it.cmd == CMD_BEACON) begin
      if (it.len < MIN_PAYLOAD) begin
        r.status = ST_SHORT;
      end else if (it.dir >= DIR_NUM) begin
        r.status = ST_BAD_DIR;
      end else if (it.sender == own_id_q) begin
        r.status = ST_OWN_ID;
      end else begin
        slot = -1;
        for (k = 0; k < tbl_n; k++) begin
          if (slot < 0 && tbl_id[k] == it.sender) slot = k;
        end
        if (slot >= 0) begin
          tbl_dir[slot] = it.dir[1:0];
          tbl_ts[slot]  = it.now;
          r.status = ST_UPDATED;
        end else if (tbl_n >= TBL_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          tbl_id[tbl_n]  = it.sender;
          tbl_dir[tbl_n] = it.dir[1:0];
          tbl_ts[tbl_n]  = it.now;
          tbl_n++;
          r.status = ST_INSERTED;
        end
      end
    end else begin
      // Walk down from the top; a stale entry takes the current last one.
      for (k = tbl_n - 1; k >= 0; k--) begin
        age = it.now - tbl_ts[k];
        if (age > {16'h0000, max_age_q}) begin
          last = tbl_n - 1;
          tbl_id[k]  = tbl_id[last];
          tbl_dir[k] = tbl_dir[last];
          tbl_ts[k]  = tbl_ts[last];
          tbl_n--;
          purged++;
        end
      end
      for (k = 0; k < DIR_NUM; k++) dir_tally[k] = 0;
      for (k = 0; k < tbl_n; k++) dir_tally[tbl_dir[k]]++;
      r.status = ST_TICK;
    end
    r.count   = 5'(tbl_n);
    r.removed = 5'(purged);
    for (k = 0; k < DIR_NUM; k++) r.dir_cnt[k] = 5'(dir_tally[k]);
    return r;
  endfunction

  function automatic int draw_gap(int quiet);
    int r;
    r = $urandom_range(0, 99);
    if (quiet > 0 || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Sender: present items from the queue, hold while stalled.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      tx_wait = 0;
    end else begin
      if (in_valid && !in_stall) expected_reports.push_back(update_neighbors(on_wire));
      if (!in_valid || !in_stall) begin
        if (tx_wait > 0 || pending_items.size() == 0) begin
          in_valid <= 1'b0;
          if (tx_wait > 0) tx_wait--;
        end else begin
          on_wire = pending_items.pop_front();
          in_valid       <= 1'b1;
          in_cmd         <= on_wire.cmd;
          in_sender_id   <= on_wire.sender;
          in_direction   <= on_wire.dir;
          in_payload_len <= on_wire.len;
          in_now_ms      <= on_wire.now;
          tx_wait = draw_gap(tx_quiet);
        end
      end
      if (tx_quiet > 0) tx_quiet--;
      else if ($urandom_range(0, 99) == 0) tx_quiet = $urandom_range(50, 200);
    end
  end

  // Receiver: check each taken result, then decide the next stall.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      rx_hold = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_reports.size() == 0) begin
          $error("result with no item pending: status %0d", out_status);
          errors++;
        end else begin
          want = expected_reports.pop_front();
          checked_total++;
          got_dirs = {out_dir_count_3, out_dir_count_2, out_dir_count_1, out_dir_count_0};
          if (out_status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_status);
            errors++;
          end
          if (out_neighbor_count !== want.count) begin
            $error("neighbor_count: expected %0d, got %0d", want.count, out_neighbor_count);
            errors++;
          end
          if (out_removed_count !== want.removed) begin
            $error("removed_count: expected %0d, got %0d", want.removed, out_removed_count);
            errors++;
          end
          for (d = 0; d < DIR_NUM; d++) begin
            if (got_dirs[d] !== want.dir_cnt[d]) begin
              $error("dir_count_%0d: expected %0d, got %0d", d, want.dir_cnt[d], got_dirs[d]);
              errors++;
            end
          end
        end
      end
      // One long hold-off so the block backs up into its input.
      if (!held_off && checked_total >= HOLD_AT) begin
        held_off = 1'b1;
        rx_hold = HOLD_LEN;
      end
      if (rx_hold > 0) begin
        out_stall <= 1'b1;
        rx_hold--;
      end else begin
        out_stall <= 1'b0;
        rx_hold = draw_gap(rx_quiet);
      end
      if (rx_quiet > 0) rx_quiet--;
      else if ($urandom_range(0, 99) == 0) rx_quiet = $urandom_range(50, 200);
    end
  end

  task automatic push_item(logic cmd, logic [15:0] sender, logic [2:0] dir,
                           logic [7:0] len, logic [31:0] ms);
    radio_item_t it;
    it.cmd    = cmd;
    it.sender = sender;
    it.dir    = dir;
    it.len    = len;
    it.now    = ms;
    pending_items.push_back(it);
    queued_total++;
  endtask

  task automatic write_reg(logic idx, logic [15:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    if (idx == CFG_OWN_ID) own_id_q = data;
    else max_age_q = data;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_idle(int settle);
    while (checked_total != queued_total) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  // Mostly well-formed beacons from a small sender pool so the table fills,
  // with ticks, time jumps and malformed beacons mixed in.
  task automatic run_random(int n, logic [31:0] start_ms);
    int i;
    int r;
    logic [31:0] t;
    logic        cmd;
    logic [15:0] sender;
    logic [2:0]  dir;
    logic [7:0]  len;
    t = start_ms;
    for (i = 0; i < POOL_SIZE; i++) pool[i] = 16'($urandom_range(0, 65535));
    if ($urandom_range(0, 1) == 1) pool[0] = own_id_q;
    for (i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 80) t = t + $urandom_range(0, 200);
      else if (r < 95) t = t + $urandom_range(0, 3000);
      else if (r < 98) t = t - $urandom_range(1, 100);
      else t = $urandom;
      sender = 16'($urandom_range(0, 65535));
      dir    = 3'($urandom_range(0, 7));
      len    = ($urandom_range(0, 1) == 1) ? 8'($urandom_range(0, 3))
                                           : 8'($urandom_range(0, 255));
      r = $urandom_range(0, 99);
      if (r < 12) begin
        cmd = CMD_TICK;
      end else begin
        cmd = CMD_BEACON;
        if (r >= 20) begin
          sender = pool[$urandom_range(0, POOL_SIZE - 1)];
          dir    = 3'($urandom_range(0, DIR_NUM - 1));
          len    = 8'($urandom_range(MIN_PAYLOAD, 255));
        end
      end
      push_item(cmd, sender, dir, len, t);
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part, reset register values: own_id 0, max age 1500.
    push_item(CMD_TICK,   16'hFFFF, 3'd7, 8'hFF, 32'd1000);
    push_item(CMD_BEACON, 16'h0005, 3'd0, 8'd0,  32'd1000);
    push_item(CMD_BEACON, 16'h0005, 3'd0, 8'd1,  32'd1000);
    push_item(CMD_BEACON, 16'h0005, 3'd4, 8'd2,  32'd1000);
    push_item(CMD_BEACON, 16'h0000, 3'd7, 8'd0,  32'd1000);
    push_item(CMD_BEACON, 16'h0000, 3'd7, 8'd255, 32'd1000);
    push_item(CMD_BEACON, 16'h0000, 3'd1, 8'd2,  32'd1000);
    push_item(CMD_BEACON, 16'hFFFF, 3'd3, 8'd255, 32'd1000);
    push_item(CMD_BEACON, 16'h1234, 3'd1, 8'd10, 32'd1100);
    push_item(CMD_BEACON, 16'hFFFF, 3'd2, 8'd2,  32'd1200);
    push_item(CMD_BEACON, 16'h00AA, 3'd0, 8'd64, 32'd1300);
    // Exactly at the age limit: kept; one past: purged.
    push_item(CMD_TICK,   16'h0000, 3'd0, 8'd0,  32'd2600);
    push_item(CMD_TICK,   16'h0000, 3'd0, 8'd0,  32'd2601);
    push_item(CMD_BEACON, 16'h7777, 3'd3, 8'd3,  32'hFFFF_FFF0);
    // Time wraps: the new entry survives, the older ones go.
    push_item(CMD_TICK,   16'h5A5A, 3'd5, 8'hAA, 32'h0000_0100);
    push_item(CMD_TICK,   16'h0000, 3'd0, 8'd0,  32'h0000_0100);
    wait_idle(8);

    write_reg(CFG_OWN_ID, 16'($urandom_range(1, 65534)));
    write_reg(CFG_MAX_AGE, 16'hFFFF);
    run_random(400, $urandom);
    wait_idle(8);

    write_reg(CFG_OWN_ID, 16'hFFFF);
    write_reg(CFG_MAX_AGE, 16'h0000);
    run_random(300, $urandom);
    wait_idle(8);

    write_reg(CFG_OWN_ID, 16'h0000);
    write_reg(CFG_MAX_AGE, MAX_AGE_RST);
    run_random(400, 32'hFFFF_F000);
    wait_idle(8);

    write_reg(CFG_MAX_AGE, 16'($urandom_range(0, 65535)));
    write_reg(CFG_OWN_ID, 16'($urandom_range(0, 65535)));
    run_random(400, $urandom);
    wait_idle(8);

    write_reg(CFG_OWN_ID, 16'($urandom_range(0, 65535)));
    write_reg(CFG_MAX_AGE, 16'd300);
    run_random(500, $urandom);
    wait_idle(150);

    if (errors == 0 && expected_reports.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+design
design/nta_pkg.sv
design/nta_ram.sv
design/nta_cmp_unit.sv
design/neighbor_table_aging.sv
dv/tb_neighbor_table_aging.sv
